// ===== design/mip_downsample_2x2_rgba_top_defines.svh =====
// Assertion macros for the mip downsample block.
`ifndef MIP_DOWNSAMPLE_2X2_RGBA_TOP_DEFINES_SVH
`define MIP_DOWNSAMPLE_2X2_RGBA_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define MIPDS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("mipds implication check failed");

`define MIPDS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("mipds next-cycle check failed");

`else

`define MIPDS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)

`define MIPDS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== design/mipds_pkg.sv =====
package mipds_pkg;

    localparam int MAX_WIDTH   = 4096;
    localparam int MAX_HEIGHT  = 4096;
    localparam int STORE_DEPTH = MAX_WIDTH / 2;

    localparam int DIM_W  = 13;
    localparam int CNT_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int ADDR_W = $clog2(STORE_DEPTH);

    localparam int CH_W   = 8;
    localparam int PAIR_W = CH_W + 1;
    localparam int VSUM_W = CH_W + 2;
    localparam int NUM_CH = 4;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 2'd1;

    typedef logic [NUM_CH-1:0][CH_W-1:0]   t_pixel;
    typedef logic [NUM_CH-1:0][PAIR_W-1:0] t_pair;
    typedef logic [NUM_CH-1:0][VSUM_W-1:0] t_store_word;

    // Register write value: low 13 bits, zero taken as one, capped at max.
    function automatic logic [DIM_W-1:0] clamp_dim(
        input logic [DIM_W-1:0] v,
        input logic [DIM_W-1:0] max_v
    );
        logic [DIM_W-1:0] d;
        d = v;
        if (d == '0) begin
            d = DIM_W'(1);
        end
        if (d > max_v) begin
            d = max_v;
        end
        return d;
    endfunction

endpackage

// ===== design/mip_downsample_2x2_rgba_top.sv =====
// The pixel ending a 2x2 block passes stage 1, then the output register, to m_tvalid.
// Throughput: one pixel in per clock while m_tready keeps up; one out per 2x2 block.
// The even-row pair sums sit in a 2048 x 40 line store (one port, read registered).
// Reset (i_rst_n low, synchronous): counters and valid flags cleared, size = 1x1.
// The line store is not cleared; no start-up pass, pixels are taken right after reset.
`include "mip_downsample_2x2_rgba_top_defines.svh"

module mip_downsample_2x2_rgba_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [mipds_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [mipds_pkg::DIM_W-1:0]          i_cfg_data,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // red_in[7:0], green_in[15:8], blue_in[23:16], alpha_in[31:24]
    input  logic [31:0]                          s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // red_out[7:0], green_out[15:8], blue_out[23:16], alpha_out[31:24]
    output logic [31:0]                          m_tdata,
    output logic                                 m_tlast
);

    localparam int DIM_W  = mipds_pkg::DIM_W;
    localparam int CNT_W  = mipds_pkg::CNT_W;
    localparam int ROW_W  = mipds_pkg::ROW_W;
    localparam int ADDR_W = mipds_pkg::ADDR_W;
    localparam int NUM_CH = mipds_pkg::NUM_CH;
    localparam int VSUM_W = mipds_pkg::VSUM_W;
    localparam int PAIR_W = mipds_pkg::PAIR_W;
    localparam int CH_W   = mipds_pkg::CH_W;

    logic [DIM_W-1:0] r_width;
    logic [DIM_W-1:0] r_height;
    logic [CNT_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic             cfg_hit;

    mipds_pkg::t_pixel      px;
    mipds_pkg::t_pixel      r_pair;
    mipds_pkg::t_pair       hs;
    mipds_pkg::t_store_word st_wdata;
    mipds_pkg::t_store_word r_rd_data;
    mipds_pkg::t_store_word mem [mipds_pkg::STORE_DEPTH];

    logic              s_acc;
    logic              w_one, h_one;
    logic [DIM_W-1:0]  lim_c, lim_r;
    logic [CNT_W-1:0]  ow_m1;
    logic [ROW_W-1:0]  oh_m1;
    logic              in_range, hready, st_wr, st_rd, emit, is_last;
    logic [1:0]        shift;
    logic [ADDR_W-1:0] st_addr;
    logic [DIM_W-1:0]  col_inc, row_inc;

    logic              r_s1_vld;
    mipds_pkg::t_pair  r_s1_hs;
    logic              r_s1_mem;
    logic [1:0]        r_s1_shift;
    logic              r_s1_last;
    logic              s1_adv;

    mipds_pkg::t_pixel res;
    logic              r_m_vld;
    mipds_pkg::t_pixel r_m_data;
    logic              r_m_last;

    assign px      = s_tdata;
    assign s1_adv  = r_s1_vld && (!r_m_vld || m_tready);
    assign s_tready = !r_s1_vld || s1_adv;
    assign s_acc   = s_tvalid && s_tready;

    // ---- configuration ----
    always_comb begin
        case (i_cfg_idx)
            mipds_pkg::CFG_SRC_WIDTH:  cfg_hit = i_cfg_we;
            mipds_pkg::CFG_SRC_HEIGHT: cfg_hit = i_cfg_we;
            default:                   cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= DIM_W'(1);
            r_height <= DIM_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mipds_pkg::CFG_SRC_WIDTH:
                    r_width  <= mipds_pkg::clamp_dim(i_cfg_data,
                                                     DIM_W'(mipds_pkg::MAX_WIDTH));
                mipds_pkg::CFG_SRC_HEIGHT:
                    r_height <= mipds_pkg::clamp_dim(i_cfg_data,
                                                     DIM_W'(mipds_pkg::MAX_HEIGHT));
                default: ;
            endcase
        end
    end

    // ---- stage 0: decode position, horizontal pair sum ----
    always_comb begin
        w_one    = (r_width == DIM_W'(1));
        h_one    = (r_height == DIM_W'(1));
        // odd last column/row falls outside 2*out_dim
        lim_c    = w_one ? DIM_W'(2) : {r_width[DIM_W-1:1], 1'b0};
        lim_r    = h_one ? DIM_W'(2) : {r_height[DIM_W-1:1], 1'b0};
        ow_m1    = w_one ? '0 : CNT_W'(r_width[DIM_W-1:1] - 1'b1);
        oh_m1    = h_one ? '0 : ROW_W'(r_height[DIM_W-1:1] - 1'b1);
        in_range = (DIM_W'(r_col) < lim_c) && (DIM_W'(r_row) < lim_r);
        hready   = in_range && (w_one || r_col[0]);
        st_wr    = hready && !h_one && !r_row[0];
        emit     = hready && (h_one || r_row[0]);
        st_rd    = emit && !h_one;
        shift    = {1'b0, !w_one} + {1'b0, !h_one};
        is_last  = (CNT_W'(r_col[CNT_W-1:1]) == ow_m1) &&
                   (ROW_W'(r_row[ROW_W-1:1]) == oh_m1);
        st_addr  = r_col[CNT_W-1:1];
        for (int k = 0; k < NUM_CH; k++) begin
            hs[k]       = w_one ? {1'b0, px[k]} : PAIR_W'({1'b0, r_pair[k]} + px[k]);
            st_wdata[k] = VSUM_W'(hs[k]);
        end
        col_inc = DIM_W'(r_col) + 1'b1;
        row_inc = DIM_W'(r_row) + 1'b1;
        n_col   = r_col;
        n_row   = r_row;
        if (cfg_hit) begin
            n_col = '0;
            n_row = '0;
        end else if (s_acc) begin
            if (col_inc >= r_width) begin
                n_col = '0;
                n_row = (row_inc >= r_height) ? '0 : ROW_W'(row_inc);
            end else begin
                n_col = CNT_W'(col_inc);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc && !w_one && !r_col[0]) begin
            r_pair <= px;
        end
    end

    // line store: written on even rows, read back on the odd row below
    always_ff @(posedge i_clk) begin
        if (s_acc && st_wr) begin
            mem[st_addr] <= st_wdata;
        end else if (s_acc && st_rd) begin
            r_rd_data <= mem[st_addr];
        end
    end

    // ---- stage 1 ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (s_acc) begin
            r_s1_vld <= emit;
        end else if (s1_adv) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_s1_hs    <= hs;
            r_s1_mem   <= !h_one;
            r_s1_shift <= shift;
            r_s1_last  <= is_last;
        end
    end

    always_comb begin
        logic [VSUM_W-1:0] v;
        for (int k = 0; k < NUM_CH; k++) begin
            v      = (r_s1_mem ? r_rd_data[k] : '0) + VSUM_W'(r_s1_hs[k]);
            res[k] = CH_W'(v >> r_s1_shift);
        end
    end

    // ---- output register ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
        end else if (s1_adv) begin
            r_m_vld <= 1'b1;
        end else if (m_tready) begin
            r_m_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_m_data <= res;
            r_m_last <= r_s1_last;
        end
    end

    assign m_tvalid = r_m_vld;
    assign m_tdata  = r_m_data;
    assign m_tlast  = r_m_last;

    // ---- checks ----
    `MIPDS_ASSERT_NXT(a_cfg_clears_pos, i_clk, i_rst_n, cfg_hit, (r_col == '0) && (r_row == '0))
    `MIPDS_ASSERT_IMP(a_col_in_width, i_clk, i_rst_n, 1'b1, DIM_W'(r_col) < r_width)
    `MIPDS_ASSERT_IMP(a_row_in_height, i_clk, i_rst_n, 1'b1, DIM_W'(r_row) < r_height)
    `MIPDS_ASSERT_NXT(a_s1_held, i_clk, i_rst_n, r_s1_vld && r_m_vld && !m_tready, r_s1_vld)

endmodule

// ===== dv/mip_downsample_2x2_rgba_top_tb.sv =====
module mip_downsample_2x2_rgba_top_tb;
    import mipds_pkg::*;

    // indexes past the register list; writes to them must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
    localparam int DRAIN_CYCLES  = 4;
    localparam int RANDOM_PIXELS = 900;
    localparam int MAX_REPORTS   = 100;

    typedef struct packed {
        t_pixel pix;
        logic   last;
    } t_out_pixel;

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx  = '0;
    logic [DIM_W-1:0]     i_cfg_data = '0;
    logic                 s_tvalid   = 1'b0;
    logic [31:0]          s_tdata    = '0;
    logic                 m_tready   = 1'b0;
    logic                 s_tready;
    logic                 m_tvalid;
    logic [31:0]          m_tdata;
    logic                 m_tlast;

    // predictor state
    logic [DIM_W-1:0] lvl_width;
    logic [DIM_W-1:0] lvl_height;
    logic [CNT_W-1:0] col_pos;
    logic [ROW_W-1:0] row_pos;
    t_pair            left_sum;
    t_store_word      even_row_sums [STORE_DEPTH];
    t_out_pixel       expected_pixels [$];

    int err_count  = 0;
    int hold_left  = 0;
    int stall_left = 0;
    bit no_idle    = 1'b0;

    string ch_names [NUM_CH] = '{"red", "green", "blue", "alpha"};

    mip_downsample_2x2_rgba_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic int rand_gap();
        int p;
        p = $urandom_range(99, 0);
        if (p < 50) begin
            return 0;
        end else if (p < 85) begin
            return $urandom_range(3, 1);
        end else if (p < 97) begin
            return $urandom_range(12, 4);
        end
        return $urandom_range(60, 20);
    endfunction

    function automatic t_pixel rand_pixel();
        t_pixel px;
        if ($urandom_range(9, 0) == 0) begin
            for (int k = 0; k < NUM_CH; k++) begin
                px[k] = $urandom_range(1, 0) ? 8'hFF : 8'h00;
            end
        end else begin
            px = $urandom;
        end
        return px;
    endfunction

    function automatic logic [DIM_W-1:0] limit_dim(input logic [DIM_W-1:0] v, input int max_v);
        if (v == '0) begin
            return DIM_W'(1);
        end
        if (int'(v) > max_v) begin
            return DIM_W'(max_v);
        end
        return v;
    endfunction

    task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
        case (idx)
            CFG_SRC_WIDTH: begin
                lvl_width = limit_dim(data, MAX_WIDTH);
                col_pos   = '0;
                row_pos   = '0;
            end
            CFG_SRC_HEIGHT: begin
                lvl_height = limit_dim(data, MAX_HEIGHT);
                col_pos    = '0;
                row_pos    = '0;
            end
            default: begin
            end
        endcase
    endtask

    // horizontal pair sum, then vertical sum against the even row, then shift
    task automatic average_pixel(input t_pixel px);
        int w, h, ow, oh, c, r, shift, idx;
        int hs [NUM_CH];
        int v  [NUM_CH];
        bit hready, emit;
        t_out_pixel res;
        w  = int'(lvl_width);
        h  = int'(lvl_height);
        ow = (w >> 1) != 0 ? (w >> 1) : 1;
        oh = (h >> 1) != 0 ? (h >> 1) : 1;
        c  = int'(col_pos);
        r  = int'(row_pos);
        if (c < 2 * ow && r < 2 * oh) begin
            hready = 1'b0;
            emit   = 1'b0;
            shift  = (w == 1) ? 0 : 1;
            if (w == 1) begin
                for (int k = 0; k < NUM_CH; k++) hs[k] = int'(px[k]);
                hready = 1'b1;
            end else if ((c % 2) == 0) begin
                for (int k = 0; k < NUM_CH; k++) left_sum[k] = PAIR_W'(px[k]);
            end else begin
                for (int k = 0; k < NUM_CH; k++) hs[k] = int'(left_sum[k]) + int'(px[k]);
                hready = 1'b1;
            end
            if (hready) begin
                idx = (c >> 1) % STORE_DEPTH;
                if (h == 1) begin
                    for (int k = 0; k < NUM_CH; k++) v[k] = hs[k];
                    emit = 1'b1;
                end else if ((r % 2) == 0) begin
                    for (int k = 0; k < NUM_CH; k++) even_row_sums[idx][k] = VSUM_W'(hs[k]);
                end else begin
                    for (int k = 0; k < NUM_CH; k++) begin
                        v[k] = int'(even_row_sums[idx][k]) + hs[k];
                    end
                    shift = shift + 1;
                    emit  = 1'b1;
                end
                if (emit) begin
                    for (int k = 0; k < NUM_CH; k++) res.pix[k] = 8'(v[k] >> shift);
                    res.last = ((c >> 1) == ow - 1) && ((r >> 1) == oh - 1);
                    expected_pixels.insert(expected_pixels.size(), res);
                end
            end
        end
        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) r = 0;
        end
        col_pos = CNT_W'(c);
        row_pos = ROW_W'(r);
    endtask

    task automatic report_mismatch(input string field, input int got, input int want);
        if (err_count < MAX_REPORTS) begin
            $display("mismatch %s: got %0d, want %0d at %0t", field, got, want, $realtime);
        end
        err_count++;
    endtask

    task automatic check_pixel();
        t_out_pixel want;
        t_pixel     got;
        got = t_pixel'(m_tdata);
        if (expected_pixels.size() == 0) begin
            report_mismatch("unexpected output pixel", int'(got), 0);
            return;
        end
        want = expected_pixels.pop_front();
        for (int k = 0; k < NUM_CH; k++) begin
            if (got[k] !== want.pix[k]) begin
                report_mismatch(ch_names[k], int'(got[k]), int'(want.pix[k]));
            end
        end
        if (m_tlast !== want.last) begin
            report_mismatch("frame_last", int'(m_tlast), int'(want.last));
        end
    endtask

    // config, input and output are observed in one place so their order is fixed
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            lvl_width  = DIM_W'(1);
            lvl_height = DIM_W'(1);
            col_pos    = '0;
            row_pos    = '0;
            left_sum   = '0;
        end else begin
            if (i_cfg_we) apply_reg(i_cfg_idx, i_cfg_data);
            if (s_tvalid && s_tready) average_pixel(t_pixel'(s_tdata));
            if (m_tvalid && m_tready) check_pixel();
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready   <= 1'b1;
                stall_left = no_idle ? 0 : rand_gap();
            end
        end
    end

    initial begin
        #50_000_000;
        $display("FAIL mip_downsample_2x2_rgba_top");
        $finish;
    end

    // called at a rising edge; returns at a rising edge
    task automatic send_pixel(input t_pixel px);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        do @(posedge i_clk); while (!s_tready);
        gap = no_idle ? 0 : rand_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_random(input int count);
        for (int i = 0; i < count; i++) send_pixel(rand_pixel());
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        // wait for an edge so that a request taken at this edge is already predicted
        @(posedge i_clk);
        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic set_size(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_SRC_WIDTH;
        i_cfg_data <= w;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_SRC_HEIGHT;
        i_cfg_data <= h;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic test_directed();
        // full 2x2 block, channel extremes and truncation
        set_size(DIM_W'(2), DIM_W'(2));
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'h0000_0000);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'h00FF_01FE);
        // zero size taken as 1x1: every pixel is its own level
        set_size(DIM_W'(0), DIM_W'(0));
        send_pixel(32'h8040_2010);
        send_pixel(32'hFFFF_FFFF);
        // single column: vertical pairs only
        set_size(DIM_W'(1), DIM_W'(2));
        send_pixel(32'hFF00_FF01);
        send_pixel(32'hFF00_00FF);
        // odd last column dropped
        set_size(DIM_W'(3), DIM_W'(1));
        send_pixel(32'h0102_0304);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'h5555_5555);
        // odd last row dropped
        set_size(DIM_W'(2), DIM_W'(3));
        for (int i = 0; i < 6; i++) send_pixel(rand_pixel());
        // writes past the register list leave the level position alone
        set_size(DIM_W'(4), DIM_W'(2));
        send_random(4);
        write_reg(CFG_SPARE_A, '1);
        send_random(2);
        write_reg(CFG_SPARE_B, '0);
        send_random(2);
    endtask

    task automatic test_clamp_largest();
        // oversize values clamp to the maximum
        set_size('1, DIM_W'(1));
        send_random(64);
        set_size(DIM_W'(1), '1);
        send_random(40);
    endtask

    task automatic test_mid_level_write();
        set_size(DIM_W'(6), DIM_W'(4));
        send_random(15);
        // rewriting a register restarts the level
        write_reg(CFG_SRC_WIDTH, DIM_W'(6));
        send_random(24);
        send_random(10);
        write_reg(CFG_SRC_HEIGHT, DIM_W'(4));
        send_random(24);
    endtask

    task automatic test_backpressure();
        set_size(DIM_W'(8), DIM_W'(4));
        no_idle   = 1'b1;
        hold_left = 300;
        send_random(96);
        no_idle = 1'b0;
        // sender pauses until every output has come back
        wait_drained();
        send_random(32);
    endtask

    task automatic test_full_rate();
        set_size(DIM_W'(16), DIM_W'(6));
        no_idle = 1'b1;
        send_random(192);
        wait_drained();
        no_idle = 1'b0;
    endtask

    task automatic test_random_levels();
        int sent, w, h, p, levels, full;
        sent = 0;
        while (sent < RANDOM_PIXELS) begin
            p = $urandom_range(99, 0);
            if (p < 80) begin
                w = $urandom_range(24, 1);
            end else if (p < 95) begin
                w = $urandom_range(64, 25);
            end else begin
                w = $urandom_range(400, 100);
            end
            h = (w > 64) ? $urandom_range(3, 1) : $urandom_range(10, 1);
            p = $urandom_range(99, 0);
            if (p < 10) begin
                write_reg(CFG_SRC_WIDTH, DIM_W'(w));
                h = int'(lvl_height);
            end else begin
                set_size(DIM_W'(w), DIM_W'(h));
            end
            if ($urandom_range(19, 0) == 0) begin
                write_reg($urandom_range(1, 0) ? CFG_SPARE_A : CFG_SPARE_B, DIM_W'($urandom));
            end
            full   = w * h;
            levels = $urandom_range(3, 1);
            for (int l = 0; l < levels; l++) begin
                // now and then a level is cut short by the next write
                if (l == levels - 1 && full > 1 && $urandom_range(7, 0) == 0) begin
                    p = $urandom_range(full - 1, 1);
                end else begin
                    p = full;
                end
                send_random(p);
                sent += p;
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_clamp_largest();
        test_mid_level_write();
        test_backpressure();
        test_full_rate();
        test_random_levels();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("PASS mip_downsample_2x2_rgba_top");
        end else begin
            $display("FAIL mip_downsample_2x2_rgba_top");
        end
        $finish;
    end

endmodule
